/* design/jvs_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jvs_pkg: shared types and constants of the JSON scalar value scanner
// Scan phases, result codes, literal spelling tables and byte classifiers.
// ----------------------------------------------------------------------------
package jvs_pkg;

  // scan phase of the current document
  typedef enum logic [4:0] {
    PH_LEAD     = 5'd0,
    PH_LIT      = 5'd1,
    PH_NSIGN    = 5'd2,
    PH_NZERO    = 5'd3,
    PH_NINT     = 5'd4,
    PH_NDOT     = 5'd5,
    PH_NFRAC    = 5'd6,
    PH_NEXP     = 5'd7,
    PH_NEXPSIGN = 5'd8,
    PH_NEXPDIG  = 5'd9,
    PH_STR      = 5'd10,
    PH_STRESC   = 5'd11,
    PH_TRAIL    = 5'd12,
    PH_ERR      = 5'd13
  } phase_t;

  // result kinds
  localparam logic [1:0] K_STR    = 2'd0;
  localparam logic [1:0] K_NUM    = 2'd1;
  localparam logic [1:0] K_STATUS = 2'd2;

  // value types
  localparam logic [2:0] T_NULL   = 3'd0;
  localparam logic [2:0] T_FALSE  = 3'd1;
  localparam logic [2:0] T_TRUE   = 3'd2;
  localparam logic [2:0] T_NUMBER = 3'd3;
  localparam logic [2:0] T_STRING = 3'd4;

  // status codes
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_EXPECT  = 3'd1;
  localparam logic [2:0] ST_INVALID = 3'd2;
  localparam logic [2:0] ST_NOTSING = 3'd3;
  localparam logic [2:0] ST_ESCAPE  = 3'd4;
  localparam logic [2:0] ST_CHAR    = 3'd5;
  localparam logic [2:0] ST_QUOTE   = 3'd6;

  // literal choices
  localparam logic [1:0] LIT_NULL  = 2'd0;
  localparam logic [1:0] LIT_TRUE  = 2'd1;
  localparam logic [1:0] LIT_FALSE = 2'd2;

  localparam logic [7:0] CTRL_LIMIT = 8'h20;

  // scanner state carried between bytes
  typedef struct packed {
    phase_t     phase;
    logic [1:0] lit_choice;
    logic [2:0] lit_pos;
    logic [2:0] found_type;
    logic [2:0] err_code;
  } scan_state_t;

  // one result transaction
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic [2:0] vtype;
    logic [2:0] status;
  } scan_res_t;

  localparam scan_state_t SCAN_RESET = '{
    phase:      PH_LEAD,
    lit_choice: LIT_NULL,
    lit_pos:    3'd0,
    found_type: T_NULL,
    err_code:   ST_OK
  };

  function automatic logic is_ws(input logic [7:0] b);
    return (b == 8'h20) || (b == 8'h09) || (b == 8'h0A) || (b == 8'h0D);
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= 8'h30) && (b <= 8'h39);
  endfunction

  // spelling of the literals, indexed by choice and position
  function automatic logic [7:0] lit_char(input logic [1:0] choice,
                                          input logic [2:0] pos);
    logic [7:0] c;
    c = 8'h00;
    case (choice)
      LIT_NULL: begin
        case (pos)
          3'd0: c = "n";
          3'd1: c = "u";
          3'd2: c = "l";
          3'd3: c = "l";
          default: c = 8'h00;
        endcase
      end
      LIT_TRUE: begin
        case (pos)
          3'd0: c = "t";
          3'd1: c = "r";
          3'd2: c = "u";
          3'd3: c = "e";
          default: c = 8'h00;
        endcase
      end
      LIT_FALSE: begin
        case (pos)
          3'd0: c = "f";
          3'd1: c = "a";
          3'd2: c = "l";
          3'd3: c = "s";
          3'd4: c = "e";
          default: c = 8'h00;
        endcase
      end
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [2:0] lit_len(input logic [1:0] choice);
    return (choice == LIT_FALSE) ? 3'd5 : 3'd4;
  endfunction

  function automatic logic [2:0] lit_type(input logic [1:0] choice);
    logic [2:0] t;
    case (choice)
      LIT_TRUE:  t = T_TRUE;
      LIT_FALSE: t = T_FALSE;
      default:   t = T_NULL;
    endcase
    return t;
  endfunction

  // simple escapes: valid flag
  function automatic logic esc_ok(input logic [7:0] b);
    return (b == "\\") || (b == "\"") || (b == "/") || (b == "b") ||
           (b == "f") || (b == "n") || (b == "r") || (b == "t");
  endfunction

  // simple escapes: decoded byte
  function automatic logic [7:0] esc_map(input logic [7:0] b);
    logic [7:0] c;
    case (b)
      "b":     c = 8'h08;
      "f":     c = 8'h0C;
      "n":     c = 8'h0A;
      "r":     c = 8'h0D;
      "t":     c = 8'h09;
      default: c = b;
    endcase
    return c;
  endfunction

endpackage

/* design/jvs_step.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jvs_step: per-byte transition of the scanner
// Given the current state and one byte, computes the next state and the
// result transaction, if any, that the byte causes.
// ----------------------------------------------------------------------------
module jvs_step (
  input  jvs_pkg::scan_state_t cur,
  input  logic [7:0]           in_b,
  output jvs_pkg::scan_state_t nxt,
  output logic                 res_valid,
  output jvs_pkg::scan_res_t   res
);
  import jvs_pkg::*;

  logic [2:0] pos_inc;
  logic       lit_bad;
  logic       is_term;

  assign is_term = (in_b == 8'h00);
  assign pos_inc = cur.lit_pos + 3'd1;
  assign lit_bad = (cur.lit_choice > LIT_FALSE) || (cur.lit_pos >= lit_len(cur.lit_choice))
                   || (in_b != lit_char(cur.lit_choice, cur.lit_pos));

  // next state
  always_comb begin
    nxt = cur;
    if (is_term) begin
      nxt = SCAN_RESET;
    end else begin
      unique case (cur.phase) inside
        PH_LEAD: begin
          if (is_ws(in_b)) begin
            nxt = cur;
          end else if (in_b == "n" || in_b == "t" || in_b == "f") begin
            nxt.lit_choice = (in_b == "n") ? LIT_NULL : (in_b == "t") ? LIT_TRUE : LIT_FALSE;
            nxt.lit_pos    = 3'd1;
            nxt.phase      = PH_LIT;
          end else if (in_b == "\"") begin
            nxt.phase = PH_STR;
          end else if (in_b == "-") begin
            nxt.phase = PH_NSIGN;
          end else if (in_b == "0") begin
            nxt.phase = PH_NZERO;
          end else if (is_digit(in_b)) begin
            nxt.phase = PH_NINT;
          end else begin
            nxt.phase = PH_ERR; nxt.err_code = ST_INVALID; nxt.found_type = T_NULL;
          end
        end
        PH_LIT: begin
          if (lit_bad) begin
            nxt.phase = PH_ERR; nxt.err_code = ST_INVALID; nxt.found_type = T_NULL;
          end else begin
            nxt.lit_pos = pos_inc;
            if (pos_inc == lit_len(cur.lit_choice)) begin
              nxt.found_type = lit_type(cur.lit_choice);
              nxt.phase      = PH_TRAIL;
            end
          end
        end
        PH_NSIGN: begin
          if (in_b == "0") begin
            nxt.phase = PH_NZERO;
          end else if (is_digit(in_b)) begin
            nxt.phase = PH_NINT;
          end else begin
            nxt.phase = PH_ERR; nxt.err_code = ST_INVALID; nxt.found_type = T_NULL;
          end
        end
        PH_NZERO, PH_NINT, PH_NFRAC: begin
          if (cur.phase != PH_NZERO && is_digit(in_b)) begin
            nxt = cur;
          end else if (in_b == "." && cur.phase != PH_NFRAC) begin
            nxt.phase = PH_NDOT;
          end else if (in_b == "e" || in_b == "E") begin
            nxt.phase = PH_NEXP;
          end else if (is_ws(in_b)) begin
            nxt.phase = PH_TRAIL; nxt.found_type = T_NUMBER;
          end else begin
            nxt.phase = PH_ERR; nxt.err_code = ST_NOTSING; nxt.found_type = T_NULL;
          end
        end
        PH_NDOT, PH_NEXPSIGN: begin
          if (is_digit(in_b)) begin
            nxt.phase = (cur.phase == PH_NDOT) ? PH_NFRAC : PH_NEXPDIG;
          end else begin
            nxt.phase = PH_ERR; nxt.err_code = ST_INVALID; nxt.found_type = T_NULL;
          end
        end
        PH_NEXP: begin
          if (in_b == "+" || in_b == "-") begin
            nxt.phase = PH_NEXPSIGN;
          end else if (is_digit(in_b)) begin
            nxt.phase = PH_NEXPDIG;
          end else begin
            nxt.phase = PH_ERR; nxt.err_code = ST_INVALID; nxt.found_type = T_NULL;
          end
        end
        PH_NEXPDIG: begin
          if (is_digit(in_b)) begin
            nxt = cur;
          end else if (is_ws(in_b)) begin
            nxt.phase = PH_TRAIL; nxt.found_type = T_NUMBER;
          end else begin
            nxt.phase = PH_ERR; nxt.err_code = ST_NOTSING; nxt.found_type = T_NULL;
          end
        end
        PH_STR: begin
          if (in_b == "\"") begin
            nxt.phase = PH_TRAIL; nxt.found_type = T_STRING;
          end else if (in_b == "\\") begin
            nxt.phase = PH_STRESC;
          end else if (in_b < CTRL_LIMIT) begin
            nxt.phase = PH_ERR; nxt.err_code = ST_CHAR; nxt.found_type = T_NULL;
          end
        end
        PH_STRESC: begin
          if (esc_ok(in_b)) begin
            nxt.phase = PH_STR;
          end else begin
            nxt.phase = PH_ERR; nxt.err_code = ST_ESCAPE; nxt.found_type = T_NULL;
          end
        end
        PH_TRAIL: begin
          if (!is_ws(in_b)) begin
            nxt.phase = PH_ERR; nxt.err_code = ST_NOTSING; nxt.found_type = T_NULL;
          end
        end
        default: nxt = cur;
      endcase
    end
  end

  // result transaction
  always_comb begin
    res_valid  = 1'b0;
    res.kind   = K_NUM;
    res.data   = in_b;
    res.vtype  = T_NULL;
    res.status = ST_OK;
    if (is_term) begin
      res_valid = 1'b1;
      res.kind  = K_STATUS;
      res.data  = 8'h00;
      unique case (cur.phase) inside
        PH_ERR:    res.status = cur.err_code;
        PH_LEAD:   res.status = ST_EXPECT;
        PH_NZERO, PH_NINT, PH_NFRAC, PH_NEXPDIG: begin
          res.status = ST_OK;
          res.vtype  = T_NUMBER;
        end
        PH_STR:    res.status = ST_QUOTE;
        PH_STRESC: res.status = ST_ESCAPE;
        PH_TRAIL: begin
          res.status = ST_OK;
          res.vtype  = cur.found_type;
        end
        default:   res.status = ST_INVALID;
      endcase
    end else begin
      unique case (cur.phase) inside
        PH_LEAD:
          res_valid = (in_b == "-") || is_digit(in_b);
        PH_NSIGN, PH_NDOT, PH_NEXPSIGN, PH_NEXPDIG:
          res_valid = is_digit(in_b);
        PH_NZERO, PH_NINT, PH_NFRAC:
          res_valid = (cur.phase != PH_NZERO && is_digit(in_b)) ||
                      (in_b == "." && cur.phase != PH_NFRAC) ||
                      (in_b == "e") || (in_b == "E");
        PH_NEXP:
          res_valid = (in_b == "+") || (in_b == "-") || is_digit(in_b);
        PH_STR: begin
          res.kind  = K_STR;
          res_valid = (in_b != "\"") && (in_b != "\\") && (in_b >= CTRL_LIMIT);
        end
        PH_STRESC: begin
          res.kind  = K_STR;
          res.data  = esc_map(in_b);
          res_valid = esc_ok(in_b);
        end
        default: res_valid = 1'b0;
      endcase
    end
  end

endmodule

/* design/json_scalar_value_scanner.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// json_scalar_value_scanner: streaming JSON scalar value checker
// Scans one JSON document a byte at a time and reports decoded bytes and a
// final status per document.
// ----------------------------------------------------------------------------
// Takes one document byte per clock cycle; a zero byte ends the document.
// Every accepted byte is handled in the cycle it arrives: one pass through the
// per-byte transition logic updates the scan state and, when the byte causes a
// result, loads the single output register. Results appear on the output in the
// cycle after the byte that caused them. The output register is the only
// buffer, so the input stalls only while a result is held there and the
// output side stalls; otherwise a byte is taken every cycle. String bytes come
// out decoded (kind 0), number characters as they appear (kind 1), and the
// terminator always gives a final status transaction (kind 2) with the value
// type and first error, after which the scanner is ready for the next document.
module json_scalar_value_scanner (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_kind,
  output logic [7:0] out_data_byte,
  output logic [2:0] out_value_type,
  output logic [2:0] out_status
);
  import jvs_pkg::*;

  scan_state_t st_r;
  scan_state_t st_nxt;
  scan_res_t   res;
  scan_res_t   res_r;
  logic        res_valid;
  logic        out_valid_r;
  logic        in_accept;

  // input stalls only while the result register is full and blocked
  assign in_stall  = out_valid_r && out_stall;
  assign in_accept = in_valid && !in_stall;

  // per-byte transition
  jvs_step u_step (
    .cur       (st_r),
    .in_b      (in_byte),
    .nxt       (st_nxt),
    .res_valid (res_valid),
    .res       (res)
  );

  // scan state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= SCAN_RESET;
    end else if (in_accept) begin
      st_r <= st_nxt;
    end
  end

  // result register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_accept && res_valid) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // result register payload
  always_ff @(posedge clk) begin
    if (in_accept && res_valid) begin
      res_r <= res;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_kind       = res_r.kind;
  assign out_data_byte  = res_r.data;
  assign out_value_type = res_r.vtype;
  assign out_status     = res_r.status;

  // a terminator always yields a final status transaction
  a_term_status: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && (in_byte == 8'h00) |=> out_valid && (out_kind == K_STATUS))
    else $error("terminator did not produce a status transaction");

  // a terminator returns the scanner to its reset state
  a_term_reset: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && (in_byte == 8'h00) |=> (st_r == SCAN_RESET))
    else $error("scanner state not cleared after terminator");

  // a latched error code only exists in the error phase
  a_err_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r.err_code != ST_OK) |-> (st_r.phase == PH_ERR))
    else $error("error code set outside the error phase");

  // nothing but the final status leaves while in the error phase
  a_err_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && (st_r.phase == PH_ERR) && (in_byte != 8'h00) |=> !(out_valid && !$past(in_stall)
      && (out_kind != K_STATUS) && !$past(out_valid_r)))
    else $error("data transaction emitted after an error");

endmodule

/* verif/json_scalar_value_scanner_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// json_scalar_value_scanner_tb: self-checking bench for the JSON value scanner
// Feeds whole documents byte by byte: first a table of short hand-picked
// documents, then random well-formed, broken and noise documents. A predictor
// tracks the scan state and queues every expected transaction; a monitor
// compares each result field by field while both sides idle and stall.
// ----------------------------------------------------------------------------
module json_scalar_value_scanner_tb;
  import jvs_pkg::*;

  localparam int N_DIR      = 25;
  localparam int RAND_BYTES = 1430;

  typedef enum int {RX_FREE, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_mode_t;
  typedef enum int {DOC_LITERAL, DOC_NUMBER, DOC_STRING} doc_kind_t;
  typedef enum int {MUT_REPLACE, MUT_TRUNCATE, MUT_CTRL, MUT_APPEND} mutation_t;

  // one directed document and, where obvious, its final status
  typedef struct {
    string      doc;
    bit         fixed;
    logic [2:0] vt;
    logic [2:0] st;
  } dir_row_t;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_byte;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [1:0] out_kind;
  logic [7:0] out_data_byte;
  logic [2:0] out_value_type;
  logic [2:0] out_status;

  // predictor state
  phase_t     sc_phase;
  logic [1:0] sc_word;
  logic [2:0] sc_pos;
  logic [2:0] sc_found;
  logic [2:0] sc_err;

  scan_res_t  results_due [$];
  logic [7:0] doc_bytes [$];
  dir_row_t   dir_rows [N_DIR];

  int         fail_cnt = 0;
  int         n_checked = 0;
  int         n_docs = 0;
  int         n_bytes = 0;
  int         n_dir_bytes = 0;
  int         burst_left = 0;
  logic [7:0] seen_status = '0;

  rx_mode_t   rx_mode = RX_FREE;
  int         rx_left = 0;

  json_scalar_value_scanner dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_byte        (in_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_kind       (out_kind),
    .out_data_byte  (out_data_byte),
    .out_value_type (out_value_type),
    .out_status     (out_status)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------- predictor

  function automatic bit blank(input logic [7:0] b);
    return b == " " || b == 8'h09 || b == 8'h0A || b == 8'h0D;
  endfunction

  function automatic bit decimal(input logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  // spelling of null / true / false, zero past the end
  function automatic logic [7:0] word_byte(input logic [1:0] sel, input logic [2:0] idx);
    logic [39:0] w;
    case (sel)
      LIT_TRUE:  w = {"true", 8'h00};
      LIT_FALSE: w = "false";
      default:   w = {"null", 8'h00};
    endcase
    return (idx < 3'd5) ? w[39 - 8 * idx -: 8] : 8'h00;
  endfunction

  function automatic void scan_fail(input logic [2:0] code);
    sc_phase = PH_ERR;
    sc_err   = code;
    sc_found = T_NULL;
  endfunction

  function automatic void scan_clear();
    sc_phase = PH_LEAD;
    sc_word  = LIT_NULL;
    sc_pos   = 3'd0;
    sc_found = T_NULL;
    sc_err   = ST_OK;
  endfunction

  // anything but whitespace after a finished value
  function automatic void scan_trail(input logic [7:0] b);
    if (!blank(b)) scan_fail(ST_NOTSING);
  endfunction

  // advance the scan by one byte; emit tells whether a transaction results
  task automatic predict_scan_byte(input logic [7:0] b, output bit emit,
                                   output scan_res_t r);
    logic [7:0] dec;
    bit         num;
    emit = 1'b0;
    num  = 1'b0;
    r    = '{kind: K_STR, data: 8'h00, vtype: T_NULL, status: ST_OK};
    if (b == 8'h00) begin
      // terminator: final status, then back to the start state
      r.kind = K_STATUS;
      emit   = 1'b1;
      case (sc_phase)
        PH_ERR:                                r.status = sc_err;
        PH_LEAD:                               r.status = ST_EXPECT;
        PH_NZERO, PH_NINT, PH_NFRAC, PH_NEXPDIG: r.vtype = T_NUMBER;
        PH_STR:                                r.status = ST_QUOTE;
        PH_STRESC:                             r.status = ST_ESCAPE;
        PH_TRAIL:                              r.vtype = sc_found;
        default:                               r.status = ST_INVALID;
      endcase
      scan_clear();
    end else begin
      case (sc_phase)
        PH_LEAD: begin
          if (b == "n" || b == "t" || b == "f") begin
            sc_word  = (b == "n") ? LIT_NULL : (b == "t") ? LIT_TRUE : LIT_FALSE;
            sc_pos   = 3'd1;
            sc_phase = PH_LIT;
          end else if (b == "\"") begin
            sc_phase = PH_STR;
          end else if (b == "-") begin
            sc_phase = PH_NSIGN;
            num = 1'b1;
          end else if (b == "0") begin
            sc_phase = PH_NZERO;
            num = 1'b1;
          end else if (decimal(b)) begin
            sc_phase = PH_NINT;
            num = 1'b1;
          end else if (!blank(b)) begin
            scan_fail(ST_INVALID);
          end
        end
        PH_LIT: begin
          if (b != word_byte(sc_word, sc_pos)) begin
            scan_fail(ST_INVALID);
          end else begin
            sc_pos = sc_pos + 3'd1;
            if (sc_pos == ((sc_word == LIT_FALSE) ? 3'd5 : 3'd4)) begin
              sc_found = (sc_word == LIT_TRUE) ? T_TRUE :
                         (sc_word == LIT_FALSE) ? T_FALSE : T_NULL;
              sc_phase = PH_TRAIL;
            end
          end
        end
        PH_NSIGN: begin
          if (decimal(b)) begin
            sc_phase = (b == "0") ? PH_NZERO : PH_NINT;
            num = 1'b1;
          end else begin
            scan_fail(ST_INVALID);
          end
        end
        PH_NZERO, PH_NINT, PH_NFRAC: begin
          if (sc_phase != PH_NZERO && decimal(b)) begin
            num = 1'b1;
          end else if (b == "." && sc_phase != PH_NFRAC) begin
            sc_phase = PH_NDOT;
            num = 1'b1;
          end else if (b == "e" || b == "E") begin
            sc_phase = PH_NEXP;
            num = 1'b1;
          end else begin
            // byte ends the number and counts as trailing text
            sc_found = T_NUMBER;
            sc_phase = PH_TRAIL;
            scan_trail(b);
          end
        end
        PH_NDOT, PH_NEXPSIGN: begin
          if (decimal(b)) begin
            sc_phase = (sc_phase == PH_NDOT) ? PH_NFRAC : PH_NEXPDIG;
            num = 1'b1;
          end else begin
            scan_fail(ST_INVALID);
          end
        end
        PH_NEXP: begin
          if (b == "+" || b == "-") begin
            sc_phase = PH_NEXPSIGN;
            num = 1'b1;
          end else if (decimal(b)) begin
            sc_phase = PH_NEXPDIG;
            num = 1'b1;
          end else begin
            scan_fail(ST_INVALID);
          end
        end
        PH_NEXPDIG: begin
          if (decimal(b)) begin
            num = 1'b1;
          end else begin
            sc_found = T_NUMBER;
            sc_phase = PH_TRAIL;
            scan_trail(b);
          end
        end
        PH_STR: begin
          if (b == "\"") begin
            sc_found = T_STRING;
            sc_phase = PH_TRAIL;
          end else if (b == "\\") begin
            sc_phase = PH_STRESC;
          end else if (b < CTRL_LIMIT) begin
            scan_fail(ST_CHAR);
          end else begin
            r.data = b;
            emit   = 1'b1;
          end
        end
        PH_STRESC: begin
          dec = 8'h00;
          case (b)
            "\\", "\"", "/": dec = b;
            "b":             dec = 8'h08;
            "f":             dec = 8'h0C;
            "n":             dec = 8'h0A;
            "r":             dec = 8'h0D;
            "t":             dec = 8'h09;
            default:         scan_fail(ST_ESCAPE);
          endcase
          if (sc_phase == PH_STRESC) begin
            sc_phase = PH_STR;
            r.data   = dec;
            emit     = 1'b1;
          end
        end
        PH_TRAIL: scan_trail(b);
        default: ;
      endcase
    end
    if (num) begin
      r.kind = K_NUM;
      r.data = b;
      emit   = 1'b1;
    end
  endtask

  // ------------------------------------------------------------------ sender

  // one byte transaction; bursts of random length with random gaps between
  task automatic send_byte(input logic [7:0] b, input bit fixed,
                           input logic [2:0] fx_vt, input logic [2:0] fx_st);
    scan_res_t r;
    bit        emit;
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) == 0) begin
        burst_left = $urandom_range(40, 120);
      end else begin
        repeat ($urandom_range(1, 6)) begin
          @(negedge clk);
          in_valid <= 1'b0;
          in_byte  <= 8'($urandom);
        end
        burst_left = $urandom_range(1, 30);
      end
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_byte  <= b;
    do @(posedge clk); while (in_stall);
    burst_left--;
    n_bytes++;
    predict_scan_byte(b, emit, r);
    if (emit) begin
      if (fixed && r.kind == K_STATUS) begin
        r.vtype  = fx_vt;
        r.status = fx_st;
      end
      results_due.push_back(r);
    end
  endtask

  // ------------------------------------------------------ random documents

  task automatic add_ws();
    repeat ($urandom_range(0, 2)) begin
      case ($urandom_range(0, 3))
        0:       doc_bytes.push_back(" ");
        1:       doc_bytes.push_back(8'h09);
        2:       doc_bytes.push_back(8'h0A);
        default: doc_bytes.push_back(8'h0D);
      endcase
    end
  endtask

  task automatic add_digits(input int lo, input int hi);
    repeat ($urandom_range(lo, hi)) doc_bytes.push_back(8'h30 + 8'($urandom_range(0, 9)));
  endtask

  task automatic add_number();
    if ($urandom_range(0, 2) == 0) doc_bytes.push_back("-");
    if ($urandom_range(0, 3) == 0) begin
      doc_bytes.push_back("0");
    end else begin
      doc_bytes.push_back(8'h30 + 8'($urandom_range(1, 9)));
      add_digits(0, 4);
    end
    if ($urandom_range(0, 1) == 1) begin
      doc_bytes.push_back(".");
      add_digits(1, 4);
    end
    if ($urandom_range(0, 2) == 0) begin
      doc_bytes.push_back($urandom_range(0, 1) ? "e" : "E");
      case ($urandom_range(0, 2))
        0:       doc_bytes.push_back("+");
        1:       doc_bytes.push_back("-");
        default: ;
      endcase
      add_digits(1, 3);
    end
  endtask

  task automatic add_string();
    logic [7:0] c;
    doc_bytes.push_back("\"");
    repeat ($urandom_range(0, 10)) begin
      case ($urandom_range(0, 9))
        6, 7: doc_bytes.push_back(8'($urandom_range(8'h80, 8'hFF)));
        8, 9: begin
          doc_bytes.push_back("\\");
          case ($urandom_range(0, 7))
            0:       doc_bytes.push_back("\\");
            1:       doc_bytes.push_back("\"");
            2:       doc_bytes.push_back("/");
            3:       doc_bytes.push_back("b");
            4:       doc_bytes.push_back("f");
            5:       doc_bytes.push_back("n");
            6:       doc_bytes.push_back("r");
            default: doc_bytes.push_back("t");
          endcase
        end
        default: begin
          c = 8'($urandom_range(8'h20, 8'h7E));
          if (c == "\"" || c == "\\") c = "_";
          doc_bytes.push_back(c);
        end
      endcase
    end
    doc_bytes.push_back("\"");
  endtask

  task automatic add_value();
    logic [1:0] sel;
    doc_kind_t  kind;
    kind = doc_kind_t'($urandom_range(0, 2));
    add_ws();
    case (kind)
      DOC_LITERAL: begin
        sel = 2'($urandom_range(0, 2));
        for (int i = 0; i < ((sel == LIT_FALSE) ? 5 : 4); i++)
          doc_bytes.push_back(word_byte(sel, 3'(i)));
      end
      DOC_NUMBER: add_number();
      default:    add_string();
    endcase
    add_ws();
  endtask

  // damage one spot of a well-formed document
  task automatic break_doc();
    int        pos;
    mutation_t how;
    how = mutation_t'($urandom_range(0, 3));
    pos = $urandom_range(0, doc_bytes.size() - 1);
    case (how)
      MUT_REPLACE:  doc_bytes[pos] = 8'($urandom_range(1, 255));
      MUT_TRUNCATE: while (doc_bytes.size() > pos) void'(doc_bytes.pop_back());
      MUT_CTRL:     doc_bytes.insert(pos, 8'($urandom_range(1, 31)));
      default:      doc_bytes.push_back(8'($urandom_range(1, 255)));
    endcase
  endtask

  task automatic build_random_doc();
    int pick;
    doc_bytes.delete();
    pick = $urandom_range(0, 9);
    if (pick == 9) begin
      repeat ($urandom_range(0, 6)) doc_bytes.push_back(8'($urandom_range(1, 255)));
    end else begin
      add_value();
      if (pick >= 7 && doc_bytes.size() > 0) break_doc();
    end
    doc_bytes.push_back(8'h00);
  endtask

  // ---------------------------------------------------------------- receiver

  // stall pattern: windows of free flow, light, heavy and periodic stalls
  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 3));
      rx_left = $urandom_range(20, 80);
    end
    rx_left--;
    case (rx_mode)
      RX_FREE:  out_stall <= 1'b0;
      RX_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
      RX_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
      default:  out_stall <= (rx_left % 3 == 0);
    endcase
  end

  // ----------------------------------------------------------------- monitor

  task automatic report_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      fail_cnt++;
    end
  endtask

  // compare each result transaction with the oldest one due
  always @(posedge clk) begin
    scan_res_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (results_due.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual kind %0d data %0d type %0d status %0d",
                 $time, out_kind, out_data_byte, out_value_type, out_status);
        fail_cnt++;
      end else begin
        want = results_due.pop_front();
        n_checked++;
        if (out_kind == K_STATUS) seen_status[out_status] = 1'b1;
        report_field("kind", want.kind, out_kind);
        report_field("data_byte", want.data, out_data_byte);
        report_field("value_type", want.vtype, out_value_type);
        report_field("status", want.status, out_status);
      end
    end
  end

  // ---------------------------------------------------------------- stimulus

  initial begin
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_byte  = 8'h00;
    scan_clear();

    dir_rows = '{
      '{"",               1'b1, T_NULL,   ST_EXPECT},
      '{" \t\r\n",        1'b1, T_NULL,   ST_EXPECT},
      '{"null",           1'b1, T_NULL,   ST_OK},
      '{" true ",         1'b1, T_TRUE,   ST_OK},
      '{"false",          1'b1, T_FALSE,  ST_OK},
      '{"nux",            1'b1, T_NULL,   ST_INVALID},
      '{"tr",             1'b1, T_NULL,   ST_INVALID},
      '{"@",              1'b1, T_NULL,   ST_INVALID},
      '{"\377",           1'b1, T_NULL,   ST_INVALID},
      '{"-",              1'b1, T_NULL,   ST_INVALID},
      '{"1.",             1'b1, T_NULL,   ST_INVALID},
      '{"2E",             1'b1, T_NULL,   ST_INVALID},
      '{"3e-",            1'b1, T_NULL,   ST_INVALID},
      '{"0123",           1'b1, T_NULL,   ST_NOTSING},
      '{"12x",            1'b1, T_NULL,   ST_NOTSING},
      '{"9 ",             1'b1, T_NUMBER, ST_OK},
      '{"-0.5e+9",        1'b0, T_NULL,   ST_OK},
      '{"\"a\\\"\\\\\\/\\b\\f\\n\\r\\t\200\377~ \"", 1'b0, T_NULL, ST_OK},
      '{"\"\\u\"",        1'b1, T_NULL,   ST_ESCAPE},
      '{"\"\\",           1'b1, T_NULL,   ST_ESCAPE},
      '{"\"\001",         1'b1, T_NULL,   ST_CHAR},
      '{"\"\037",         1'b1, T_NULL,   ST_CHAR},
      '{"\"ab",           1'b1, T_NULL,   ST_QUOTE},
      '{"null x",         1'b1, T_NULL,   ST_NOTSING},
      '{"\"\"",           1'b1, T_STRING, ST_OK}
    };

    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    // directed documents, each closed by the terminator
    foreach (dir_rows[i]) begin
      for (int j = 0; j < dir_rows[i].doc.len(); j++)
        send_byte(dir_rows[i].doc[j], 1'b0, T_NULL, ST_OK);
      send_byte(8'h00, dir_rows[i].fixed, dir_rows[i].vt, dir_rows[i].st);
      n_docs++;
    end
    n_dir_bytes = n_bytes;

    // random documents
    while (n_bytes - n_dir_bytes < RAND_BYTES) begin
      build_random_doc();
      foreach (doc_bytes[k]) send_byte(doc_bytes[k], 1'b0, T_NULL, ST_OK);
      n_docs++;
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);

    $display("scanned %0d documents in %0d bytes (%0d directed), %0d results compared",
             n_docs, n_bytes, n_dir_bytes, n_checked);
    $display("final status codes observed (one bit per code): %b", seen_status);
    if (fail_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // run limit
  initial begin
    #2_000_000;
    $display("timeout: %0d results still due", results_due.size());
    $display("CHECK FAILED");
    $finish;
  end

endmodule

/* json_scalar_value_scanner.f */
design/jvs_pkg.sv
design/jvs_step.sv
design/json_scalar_value_scanner.sv
verif/json_scalar_value_scanner_tb.sv
